[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a named clock and active-low reset
`define ASSERT_CLK(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
        else $error(msg);

// Check a property on the block clock clk and reset rst_n
`define ASSERT_STD(label, prop, msg) \
    `ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

[hw/rtl/olar_pkg.sv]
// ----------------------------------------------------------------------------
// olar_pkg
// Types and codes shared by the ordered list block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package olar_pkg;

    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    // Action codes
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
        logic [CNT_W-1:0]         count;
    } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/ordered_list_append_remove.sv]
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// Ordered list of signed 32-bit values in a RAM: append at tail, remove
// first match with compaction, dump head to tail.
// ----------------------------------------------------------------------------
//  channel   signals              handshake
//  request   req (req_t)          beat taken at clk edge with start && !busy
//  response  rsp (rsp_t)          beat shown one cycle while strobe is high
//
//  Append is decided on the request; its result shows in the next cycle.
//  Unused codes give no result. Remove on a non-empty list holds busy: one
//  RAM read per entry during the search, then one read and one write per
//  cycle while closing the gap; the result shows as busy drops.
//  Dump streams count results, one per cycle, set by the single read port.
//  Reset clears the control state and entry count; no clearing pass over the RAM.
//  The receiver cannot stall; busy holds off requests during remove and dump.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_append_remove
    import olar_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output rsp_t      rsp,
    output logic      strobe
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_DUMP   = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    rsp_t                     rsp_reg, rsp_next;
    logic                     strobe_reg, strobe_next;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [DATA_W-1:0]        wdata;
    logic [DATA_W-1:0]        rdata;
    logic [CNT_W-1:0]         idx_plus1;
    logic                     more;
    logic                     accept;

    // Entry storage; while shifting, the write trails the read by one or two slots,
    // so the two ports never touch the same entry in the same shift cycle
    olar_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_next),
        .rdata (rdata)
    );

    assign accept    = start && (state_reg == S_IDLE);
    assign idx_plus1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign more      = idx_plus1 < count_reg;

    // Sequence the list operations
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        value_next  = value_reg;
        strobe_next = 1'b0;
        rsp_next    = '{status: ST_OK, element: '0, last: 1'b1, count: count_reg};
        we          = 1'b0;
        waddr       = count_reg[ADDR_W-1:0];
        wdata       = req.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next = req.value;
                    idx_next   = '0;
                    unique case (req.action)
                        ACT_APPEND:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg >= FULL_CNT)
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                we             = 1'b1;
                                count_next     = count_reg + CNT_W'(1);
                                rsp_next.count = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next     = 1'b1;
                                rsp_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next     = 1'b1;
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            // Drop unused action codes
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                // rdata holds entry idx_reg
                if (rdata == value_reg)
                begin
                    if (more)
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next     = count_reg - CNT_W'(1);
                        rsp_next.count = count_reg - CNT_W'(1);
                        strobe_next    = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (more)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                    strobe_next     = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_SHIFT:
            begin
                // Move entry idx_reg one slot toward the head
                we    = 1'b1;
                waddr = idx_reg - ADDR_W'(1);
                wdata = rdata;
                if (more)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
                else
                begin
                    count_next     = count_reg - CNT_W'(1);
                    rsp_next.count = count_reg - CNT_W'(1);
                    strobe_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_DUMP:
            begin
                // Emit entry idx_reg, advance until the tail
                strobe_next      = 1'b1;
                rsp_next.element = signed'(rdata);
                rsp_next.last    = !more;
                if (more)
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        rsp_reg   <= rsp_next;
    end

    assign busy   = !accept && (state_reg != S_IDLE);
    assign rsp    = rsp_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

[hw/rtl/olar_ram.sv]
// ----------------------------------------------------------------------------
// olar_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module olar_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/olar_checker.sv]
// ----------------------------------------------------------------------------
// olar_checker
// Port-level checks on the ordered list block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module olar_checker
    import olar_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire req_t req,
    input wire rsp_t rsp,
    input wire logic strobe
);

    logic append_take;

    // Flag an accepted append beat
    assign append_take = start && !busy && (req.action == ACT_APPEND);

    // Count never passes capacity
    `ASSERT_STD(a_count_cap, strobe |-> (rsp.count <= CNT_W'(DEPTH)), "count above depth")

    // Every non-ok status ends its item
    `ASSERT_STD(a_err_last, (strobe && (rsp.status != ST_OK)) |-> rsp.last, "error beat not last")

    // Append answers in the next cycle
    `ASSERT_STD(a_append_lat, append_take |=> (strobe && rsp.last), "append result missing")

    // A dump streams without gaps
    `ASSERT_STD(a_dump_stream, (strobe && !rsp.last) |=> strobe, "gap in dump stream")

    // The block is free again once an item's last beat shows
    `ASSERT_STD(a_last_free, (strobe && rsp.last) |-> !busy, "busy after last beat")

endmodule

bind ordered_list_append_remove olar_checker #(.DEPTH(DEPTH)) u_olar_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .rsp    (rsp),
    .strobe (strobe)
);

`default_nettype wire

[sim/tb_ordered_list_append_remove.sv]
// ----------------------------------------------------------------------------
// tb_ordered_list_append_remove
// Self-checking bench for the ordered list block. Drives append, remove,
// dump and unused-code beats with random sender gaps, predicts every response
// beat from a private copy of the list, and compares each strobed beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ordered_list_append_remove;

    import olar_pkg::*;

    localparam int DEPTH     = 16;
    localparam int CLK_HALF  = 6;
    localparam int RAND_BEATS = 250;
    localparam int SEG_LEN   = 35;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow list, queue of predicted response beats
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic signed [DATA_W-1:0] held[$];
        rsp_t                     expected_q[$];
        int                       errors;
        int                       n_requests;
        int                       n_responses;
        int                       n_full;
        int                       n_not_found;
        int                       n_empty;
        int                       n_dump_beats;

        function new();
            errors       = 0;
            n_requests   = 0;
            n_responses  = 0;
            n_full       = 0;
            n_not_found  = 0;
            n_empty      = 0;
            n_dump_beats = 0;
        endfunction

        function void push_expect(logic [1:0] st, logic signed [DATA_W-1:0] el,
                                  logic lst);
            rsp_t r;
            r.status  = st;
            r.element = el;
            r.last    = lst;
            r.count   = CNT_W'(held.size());
            expected_q.push_back(r);
        endfunction

        // Format the fields of one response beat
        function string fmt_rsp(rsp_t r);
            return $sformatf("status=%0d element=%0d last=%0d count=%0d",
                             r.status, r.element, r.last, r.count);
        endfunction

        // Apply one accepted request beat to the shadow list
        function void note_request(req_t beat);
            int hit;
            hit = -1;
            n_requests++;
            case (beat.action)
                ACT_APPEND:
                begin
                    if (held.size() >= DEPTH)
                    begin
                        n_full++;
                        push_expect(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        held.push_back(beat.value);
                        push_expect(ST_OK, '0, 1'b1);
                    end
                end
                ACT_REMOVE:
                begin
                    foreach (held[i])
                        if (hit < 0 && held[i] === beat.value)
                            hit = i;
                    if (hit < 0)
                    begin
                        n_not_found++;
                        push_expect(ST_NOT_FOUND, '0, 1'b1);
                    end
                    else
                    begin
                        held.delete(hit);
                        push_expect(ST_OK, '0, 1'b1);
                    end
                end
                ACT_DUMP:
                begin
                    if (held.size() == 0)
                    begin
                        n_empty++;
                        push_expect(ST_EMPTY, '0, 1'b1);
                    end
                    else
                    begin
                        foreach (held[i])
                            push_expect(ST_OK, held[i], i == held.size() - 1);
                        n_dump_beats += held.size();
                    end
                end
                default:
                begin
                    // unused code: no response, list unchanged
                end
            endcase
        endfunction

        // Compare one strobed response beat with the oldest prediction
        function void check_response(rsp_t got);
            rsp_t exp_r;
            n_responses++;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %s",
                         $time, fmt_rsp(got));
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.status !== exp_r.status || got.element !== exp_r.element ||
                got.last !== exp_r.last || got.count !== exp_r.count)
            begin
                errors++;
                $display("%0t: response mismatch, expected %s, actual %s",
                         $time, fmt_rsp(exp_r), fmt_rsp(got));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and clock
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    rsp_t rsp;
    logic strobe;

    list_scoreboard sb;

    ordered_list_append_remove #(
        .DEPTH (DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .rsp    (rsp),
        .strobe (strobe)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Sample response beats at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            sb.check_response(rsp);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Hold one request beat until the block takes it, then step to the falling edge
    task automatic send_beat(input logic [1:0] act, input logic signed [DATA_W-1:0] val);
        req_t beat;
        beat.action = act;
        beat.value  = val;
        start = 1'b1;
        req   = beat;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(beat);
        @(negedge clk);
    endtask

    // Drop start and hold junk on the request bus through an idle gap
    task automatic idle_cycles(input int n);
        start      = 1'b0;
        req.action = 2'($urandom);
        req.value  = $urandom;
        repeat (n) @(negedge clk);
    endtask

    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 99) < 25)
            idle_cycles($urandom_range(1, 4));
    endtask

    // Mix of extremes, a small pool that makes duplicates, and full-range values
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return DATA_W'($urandom_range(1, 8));
            default: return $urandom;
        endcase
    endfunction

    // Mostly search for a value that is held, sometimes for anything
    function automatic logic signed [DATA_W-1:0] pick_remove_value();
        if (sb.held.size() > 0 && $urandom_range(0, 99) < 75)
            return sb.held[$urandom_range(0, sb.held.size() - 1)];
        return pick_value();
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int useful;
        int mode;
        int roll;
        int w_app;
        int w_rem;
        int waited;
        int leftover;
        logic [1:0] act;
        bit quiet;

        sb    = new();
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty-list cases, extremes, duplicates, only-entry removal
        send_beat(ACT_DUMP,   32'sd0);
        send_beat(ACT_REMOVE, 32'sd5);
        send_beat(ACT_APPEND, 32'sh8000_0000);
        send_beat(ACT_REMOVE, 32'sh8000_0000);
        send_beat(ACT_DUMP,   32'sd0);
        send_beat(ACT_APPEND, 32'sh8000_0000);
        send_beat(ACT_APPEND, 32'sh7fff_ffff);
        idle_cycles(3);
        send_beat(ACT_APPEND, 32'sd0);
        send_beat(ACT_APPEND, -32'sd1);
        send_beat(ACT_APPEND, 32'sd5);
        send_beat(ACT_APPEND, 32'sd5);
        send_beat(ACT_DUMP,   32'sd0);
        send_beat(ACT_REMOVE, 32'sh7fff_fffe);
        send_beat(ACT_REMOVE, 32'sd5);
        send_beat(ACT_REMOVE, 32'sd0);
        send_beat(ACT_UNUSED, 32'sh7fff_ffff);
        send_beat(ACT_DUMP,   -32'sd1);
        send_beat(ACT_REMOVE, 32'sh8000_0000);
        send_beat(ACT_REMOVE, 32'sd5);
        idle_cycles(1);
        send_beat(ACT_UNUSED, 32'sh8000_0000);
        send_beat(ACT_DUMP,   32'sd0);

        // Random: segments alternate fill, drain and mixed weighting
        useful = 0;
        while (useful < RAND_BEATS)
        begin
            mode = (useful / SEG_LEN) % 3;
            case (mode)
                0:       begin w_app = 65; w_rem = 15; end
                1:       begin w_app = 15; w_rem = 65; end
                default: begin w_app = 40; w_rem = 35; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < w_app)
                act = ACT_APPEND;
            else if (roll < w_app + w_rem)
                act = ACT_REMOVE;
            else if (roll < 95)
                act = ACT_DUMP;
            else
                act = ACT_UNUSED;

            if (act == ACT_REMOVE)
                send_beat(act, pick_remove_value());
            else
                send_beat(act, pick_value());
            if (act != ACT_UNUSED)
                useful++;

            // Keep a long back-to-back stretch in the middle of the run
            quiet = (useful >= 120 && useful < 200);
            maybe_idle(!quiet);
        end
        start = 1'b0;

        // Drain: wait for every predicted beat, up to a bound, then idle on to catch stray beats
        waited = 0;
        while (sb.pending() > 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (40) @(negedge clk);

        leftover = sb.pending();
        if (leftover > 0)
            $display("%0t: %0d predicted responses never arrived", $time, leftover);

        $display("Sent %0d requests, checked %0d responses (%0d dump entries).",
                 sb.n_requests, sb.n_responses, sb.n_dump_beats);
        $display("Saw %0d full, %0d not-found and %0d empty-list responses.",
                 sb.n_full, sb.n_not_found, sb.n_empty);
        if (sb.errors == 0 && leftover == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
